// ===== hw/rtl/tilt_angle_kalman_filter_defines.svh =====
// Assertion macros for the tilt angle Kalman filter.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef TILT_ANGLE_KALMAN_FILTER_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TKF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tkf_pkg.sv =====
// Shared constants and types of the tilt angle Kalman filter.
// No dependencies; used by the channel interfaces and the top level.
package tkf_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  localparam int unsigned AccW  = 25;
  localparam int unsigned RateW = 32;
  localparam int unsigned EstW  = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned AddrW = 4;

  localparam longint QAngleRst = 66;
  localparam longint QGyroRst  = 197;
  localparam longint RMeasRst  = 32768;
  localparam longint DtRst     = 328;

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_GYRO  = 2'd1,
    REG_R_MEAS  = 2'd2,
    REG_DT      = 2'd3
  } reg_e;

endpackage

// ===== hw/rtl/tkf_if.sv =====
// Valid/ready channel interfaces for input samples and filter results.
// Depends on tkf_pkg for the field widths.
interface tkf_in_if;
  import tkf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AccW-1:0]  acc_angle;
  logic signed [RateW-1:0] gyro_rate;
  modport source (output valid, acc_angle, gyro_rate, input ready);
  modport sink   (input valid, acc_angle, gyro_rate, output ready);
endinterface

interface tkf_out_if;
  import tkf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [EstW-1:0] angle_estimate;
  logic signed [EstW-1:0] bias_estimate;
  modport source (output valid, angle_estimate, bias_estimate, input ready);
  modport sink   (input valid, angle_estimate, bias_estimate, output ready);
endinterface

// ===== hw/rtl/tilt_angle_kalman_filter.sv =====
// Two-state (angle, gyro bias) Kalman filter, top level.
// Depends on tkf_pkg, tkf_if.sv and tilt_angle_kalman_filter_defines.svh.
//
//   port     dir  item                          handshake
//   in_i     in   acc_angle, gyro_rate          valid/ready
//   out_o    out  angle_estimate, bias_estimate valid/ready
//   psel...  in   APB register writes/reads     pready tied high
//
// Each item runs its arithmetic steps in turn; when P00 + r is not positive
// both divides are skipped and the two gains are set to zero.
// The steps share one bit-serial multiplier (one bit per cycle)
// and one restoring divider (one quotient bit per cycle), used in turn.
// Reset loads the register defaults and the initial state; no clearing pass.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and a result stalls only while the previous one is still held.
`include "tilt_angle_kalman_filter_defines.svh"

module tilt_angle_kalman_filter #(
  parameter int unsigned DATA_WIDTH = tkf_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = tkf_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tkf_in_if.sink                   in_i,
  tkf_out_if.source                out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [tkf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import tkf_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned DW   = W + F;
  localparam int unsigned CntW = $clog2(DW + 1);

  localparam logic signed [W-1:0] VMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMin = {1'b1, {(W-1){1'b0}}};
  localparam longint VMax64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam longint VMin64 = -VMax64 - 64'sd1;
  localparam longint One64  = 64'sd1 <<< F;
  localparam logic signed [W-1:0] OneVal = (One64 > VMax64) ? VMax : W'(One64);

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_RES   = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  // Arithmetic steps of one item, in order.
  typedef enum logic [3:0] {
    SP_PRED_ANG = 4'd0,
    SP_PRED_P00 = 4'd1,
    SP_PRED_P01 = 4'd2,
    SP_GAIN0    = 4'd3,
    SP_GAIN1    = 4'd4,
    SP_ANG_UPD  = 4'd5,
    SP_BIAS_UPD = 4'd6,
    SP_P00_A    = 4'd7,
    SP_P10      = 4'd8,
    SP_P01_A    = 4'd9,
    SP_P11      = 4'd10
  } step_e;

  typedef logic signed [W-1:0] val_t;

  // Saturating add or subtract at the data width.
  function automatic val_t sat_as(input val_t a, input val_t b, input logic sub);
    logic [W:0] s;
    begin
      s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
      if (s[W] != s[W-1]) return s[W] ? VMin : VMax;
      return val_t'(s[W-1:0]);
    end
  endfunction

  function automatic logic [W-1:0] mag(input val_t v);
    begin
      return v[W-1] ? W'(-v) : W'(v);
    end
  endfunction

  function automatic val_t clamp64(input longint v);
    begin
      if (v > VMax64) return VMax;
      if (v < VMin64) return VMin;
      return W'(v);
    end
  endfunction

  function automatic val_t cfg_val(input logic [CfgW-1:0] v);
    begin
      if (64'(v) > 64'(VMax64)) return VMax;
      return W'(v);
    end
  endfunction

  // Control and filter state.
  state_e            state_q, state_d;
  step_e             step_q, step_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              is_div_q, is_div_d;
  logic              out_valid_q, out_valid_d;
  val_t              angle_q, angle_d, bias_q, bias_d;
  val_t              c00_q, c00_d, c01_q, c01_d, c10_q, c10_d, c11_q, c11_d;
  val_t              qa_q, qa_d, qg_q, qg_d, rm_q, rm_d, dt_q, dt_d;

  // Datapath.
  val_t              acc_q, acc_d, rate_q, rate_d;
  logic [W-1:0]      mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [2*W-1:0]    prod_q, prod_d;
  logic [DW-1:0]     dvd_q, dvd_d, quo_q, quo_d;
  logic [W-2:0]      rem_q, rem_d;
  val_t              den_q, den_d;
  logic              neg_q, neg_d;
  val_t              res_q, res_d, k0_q, k0_d, k1_q, k1_d, e_q, e_d, tmp_q, tmp_d;
  logic [EstW-1:0]   oang_q, oang_d, obias_q, obias_d;

  logic              out_free;
  logic              cfg_wr;
  val_t              op_a, op_b, den_c, e_c;
  logic [W:0]        mul_sum;
  logic [W-1:0]      rem_sh;
  logic              rem_ge;
  logic [W-1:0]      lim;
  logic [2*W-F-1:0]  prod_hi;
  logic [W-1:0]      res_mag;

  assign out_free = !out_valid_q || out_o.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.angle_estimate = oang_q;
  assign out_o.bias_estimate  = obias_q;

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_Q_ANGLE: prdata = 32'(qa_q);
      REG_Q_GYRO:  prdata = 32'(qg_q);
      REG_R_MEAS:  prdata = 32'(rm_q);
      REG_DT:      prdata = 32'(dt_q);
    endcase
  end

  assign den_c = sat_as(c00_q, rm_q, 1'b0);
  assign e_c   = sat_as(acc_q, angle_q, 1'b1);

  // Operand select for multiply steps.
  always_comb begin
    op_a = k1_q;
    op_b = c01_q;
    unique case (step_q)
      SP_PRED_ANG: begin op_a = sat_as(rate_q, bias_q, 1'b1); op_b = dt_q; end
      SP_PRED_P00: begin op_a = sat_as(c01_q, c10_q, 1'b0); op_b = dt_q; end
      SP_PRED_P01: begin op_a = c11_q; op_b = dt_q; end
      SP_ANG_UPD:  begin op_a = k0_q; op_b = e_c; end
      SP_BIAS_UPD: begin op_a = k1_q; op_b = e_q; end
      SP_P00_A:    begin op_a = k0_q; op_b = c00_q; end
      SP_P10:      begin op_a = k1_q; op_b = c00_q; end
      SP_P01_A:    begin op_a = k0_q; op_b = c01_q; end
      default:     begin op_a = k1_q; op_b = c01_q; end
    endcase
  end

  // Serial arithmetic: one multiplier bit or one quotient bit per cycle.
  assign mul_sum = {1'b0, prod_q[2*W-1:W]} + (mul_b_q[0] ? {1'b0, mul_a_q} : '0);
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_ge  = (rem_sh >= W'(den_q));
  assign lim     = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign prod_hi = prod_q[2*W-1:F];

  always_comb begin
    if (is_div_q) begin
      res_mag = (quo_q > DW'(lim)) ? lim : quo_q[W-1:0];
    end else begin
      res_mag = (prod_hi > (2*W-F)'(lim)) ? lim : prod_hi[W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;   step_d = step_q;     cnt_d = cnt_q;
    is_div_d = is_div_q; out_valid_d = out_valid_q;
    angle_d = angle_q;   bias_d = bias_q;
    c00_d = c00_q; c01_d = c01_q; c10_d = c10_q; c11_d = c11_q;
    qa_d = qa_q; qg_d = qg_q; rm_d = rm_q; dt_d = dt_q;
    acc_d = acc_q; rate_d = rate_q;
    mul_a_d = mul_a_q; mul_b_d = mul_b_q; prod_d = prod_q;
    dvd_d = dvd_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    res_d = res_q; k0_d = k0_q; k1_d = k1_q; e_d = e_q; tmp_d = tmp_q;
    oang_d = oang_q; obias_d = obias_q;

    if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_Q_ANGLE: qa_d = cfg_val(pwdata[CfgW-1:0]);
        REG_Q_GYRO:  qg_d = cfg_val(pwdata[CfgW-1:0]);
        REG_R_MEAS:  rm_d = cfg_val(pwdata[CfgW-1:0]);
        REG_DT:      dt_d = cfg_val(pwdata[CfgW-1:0]);
      endcase
    end

    // Drop the result once taken.
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          acc_d   = clamp64(64'(in_i.acc_angle));
          rate_d  = clamp64(64'(in_i.gyro_rate));
          step_d  = SP_PRED_ANG;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (step_q == SP_GAIN0 || step_q == SP_GAIN1) begin
          if (step_q == SP_GAIN0) den_d = den_c;
          if (step_q == SP_GAIN0 && (den_c[W-1] || den_c == '0)) begin
            // Non-positive denominator: zero gains, skip both divides.
            k0_d   = '0;
            k1_d   = '0;
            step_d = SP_ANG_UPD;
          end else begin
            neg_d    = (step_q == SP_GAIN0) ? c00_q[W-1] : c10_q[W-1];
            dvd_d    = {mag((step_q == SP_GAIN0) ? c00_q : c10_q), {F{1'b0}}};
            rem_d    = '0;
            quo_d    = '0;
            cnt_d    = CntW'(DW);
            is_div_d = 1'b1;
            state_d  = ST_DIV;
          end
        end else begin
          if (step_q == SP_ANG_UPD) e_d = e_c;
          mul_a_d  = mag(op_a);
          mul_b_d  = mag(op_b);
          neg_d    = op_a[W-1] ^ op_b[W-1];
          prod_d   = '0;
          cnt_d    = CntW'(W);
          is_div_d = 1'b0;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = {mul_sum, prod_q[W-1:1]};
        mul_b_d = mul_b_q >> 1;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = ST_RES;
      end
      ST_DIV: begin
        rem_d = rem_ge ? (W-1)'(rem_sh - W'(den_q)) : (W-1)'(rem_sh);
        dvd_d = dvd_q << 1;
        quo_d = {quo_q[DW-2:0], rem_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = ST_RES;
      end
      ST_RES: begin
        res_d   = neg_q ? val_t'(-res_mag) : val_t'(res_mag);
        state_d = ST_WB;
      end
      ST_WB: begin
        state_d = ST_SETUP;
        step_d  = step_e'(step_q + 1'b1);
        unique case (step_q)
          SP_PRED_ANG: angle_d = sat_as(angle_q, res_q, 1'b0);
          SP_PRED_P00: c00_d = sat_as(sat_as(c00_q, qa_q, 1'b0), res_q, 1'b1);
          SP_PRED_P01: begin
            c01_d = sat_as(c01_q, res_q, 1'b1);
            c10_d = sat_as(c10_q, res_q, 1'b1);
            c11_d = sat_as(c11_q, qg_q, 1'b0);
          end
          SP_GAIN0:    k0_d = res_q;
          SP_GAIN1:    k1_d = res_q;
          SP_ANG_UPD:  angle_d = sat_as(angle_q, res_q, 1'b0);
          SP_BIAS_UPD: bias_d = sat_as(bias_q, res_q, 1'b0);
          SP_P00_A:    tmp_d = res_q;
          SP_P10: begin
            c10_d = sat_as(c10_q, res_q, 1'b1);
            c00_d = sat_as(c00_q, tmp_q, 1'b1);
          end
          SP_P01_A:    tmp_d = res_q;
          SP_P11: begin
            c11_d   = sat_as(c11_q, res_q, 1'b1);
            c01_d   = sat_as(c01_q, tmp_q, 1'b1);
            step_d  = SP_PRED_ANG;
            state_d = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        // Hold here until the output register is free.
        if (out_free) begin
          oang_d      = EstW'(angle_q);
          obias_d     = EstW'(bias_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= SP_PRED_ANG;
      cnt_q       <= '0;
      is_div_q    <= 1'b0;
      out_valid_q <= 1'b0;
      angle_q     <= '0;
      bias_q      <= '0;
      c00_q       <= OneVal;
      c01_q       <= '0;
      c10_q       <= '0;
      c11_q       <= OneVal;
      qa_q        <= clamp64(QAngleRst);
      qg_q        <= clamp64(QGyroRst);
      rm_q        <= clamp64(RMeasRst);
      dt_q        <= clamp64(DtRst);
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      is_div_q    <= is_div_d;
      out_valid_q <= out_valid_d;
      angle_q     <= angle_d;
      bias_q      <= bias_d;
      c00_q       <= c00_d;
      c01_q       <= c01_d;
      c10_q       <= c10_d;
      c11_q       <= c11_d;
      qa_q        <= qa_d;
      qg_q        <= qg_d;
      rm_q        <= rm_d;
      dt_q        <= dt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    rate_q  <= rate_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= prod_d;
    dvd_q   <= dvd_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
    k0_q    <= k0_d;
    k1_q    <= k1_d;
    e_q     <= e_d;
    tmp_q   <= tmp_d;
    oang_q  <= oang_d;
    obias_q <= obias_d;
  end

  `TKF_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "accepted item did not block input")
  `TKF_ASSERT_NEXT(a_result_loaded, state_q == ST_OUT && out_free, out_o.valid && state_q == ST_IDLE, "result not loaded")
  `TKF_ASSERT_IMPL(a_serial_count, state_q == ST_MUL || state_q == ST_DIV, cnt_q != '0, "serial counter ran out")

endmodule
